>>> hdl/kmgd_pkg.sv
package kmgd_pkg;

   // default board store size
   localparam int DEF_MAX_COLS = 32;
   localparam int DEF_MAX_ROWS = 64;

   // item field widths
   localparam int X_FIELD_W = 5;
   localparam int Y_FIELD_W = 6;
   localparam int MOVE_W    = 11;

   // configuration registers
   localparam int COLS_W     = 6;
   localparam int ROWS_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_ROWS = 2'd1;
   localparam logic [COLS_W-1:0]    COLS_RESET     = 6'd8;
   localparam logic [ROWS_W-1:0]    ROWS_RESET     = 7'd8;

   // compare widths: hold the largest extent plus one
   localparam int COL_CMP_W = 7;
   localparam int ROW_CMP_W = 8;

   // knight moves
   localparam int NUM_STEPS = 8;
   localparam int STEP_W    = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_LOAD,
      ST_EXPAND,
      ST_DONE
   } state_type;

   function automatic logic signed [2:0] step_dx(input logic [2:0] k);
      logic signed [2:0] d;
      unique case (k)
         3'd0, 3'd1: d = 3'sd1;
         3'd2, 3'd3: d = -3'sd1;
         3'd4, 3'd5: d = 3'sd2;
         default:    d = -3'sd2;
      endcase
      return d;
   endfunction

   function automatic logic signed [2:0] step_dy(input logic [2:0] k);
      logic signed [2:0] d;
      unique case (k)
         3'd0, 3'd2: d = 3'sd2;
         3'd1, 3'd3: d = -3'sd2;
         3'd4, 3'd6: d = 3'sd1;
         default:    d = -3'sd1;
      endcase
      return d;
   endfunction

endpackage

>>> hdl/kmgd_ifs.sv
// query channel
interface kmgd_req_if
   import kmgd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [X_FIELD_W-1:0] src_x;
   logic [Y_FIELD_W-1:0] src_y;
   logic [X_FIELD_W-1:0] dst_x;
   logic [Y_FIELD_W-1:0] dst_y;

   modport source (output valid, src_x, src_y, dst_x, dst_y, input ready);
   modport sink   (input valid, src_x, src_y, dst_x, dst_y, output ready);
endinterface

// result channel
interface kmgd_rsp_if
   import kmgd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MOVE_W-1:0] move_count;
   logic              reachable;

   modport source (output valid, move_count, reachable, input ready);
   modport sink   (input valid, move_count, reachable, output ready);
endinterface

// register write channel
interface kmgd_csr_if
   import kmgd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/kmgd_sync_ram.sv
// one write port, one read port, registered read data
module kmgd_sync_ram
   import kmgd_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/knight_move_grid_distance.sv
// Channel   Direction  Payload
// req_if    in         src_x, src_y, dst_x, dst_y
// rsp_if    out        move_count, reachable
// csr_if    in         index, data (0 board_cols, 1 board_rows)
//
// A query with a square off the board skips the search and goes straight to the answer.
// Otherwise the visited map is cleared first, one entry a cycle (all
// 2**(XW+YW) entries, 2048 at default size), then each square taken from the
// queue goes through a queue read, 8 neighbor lookups and one drain, bound by
// the single read port of the visited map.
// Reset is synchronous; it sets board_cols and board_rows to 8 and idles.
// The result sits in an output register; a new query is taken while it waits.
module knight_move_grid_distance
   import kmgd_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input logic       clock,
   input logic       reset,
   kmgd_req_if.sink  req_if,
   kmgd_rsp_if.source rsp_if,
   kmgd_csr_if.sink  csr_if
);

   localparam int XW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int YW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int VAW    = XW + YW;
   localparam int VDEPTH = 2 ** VAW;
   localparam int NUM_SQ = MAX_COLS * MAX_ROWS;
   localparam int QAW    = (NUM_SQ > 1) ? $clog2(NUM_SQ) : 1;
   localparam int QIW    = $clog2(NUM_SQ + 1);
   localparam int DW     = QAW;
   localparam int QW     = DW + YW + XW;

   state_type state_ff, state_in;

   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;

   logic [XW-1:0]     src_x_ff, src_x_in, dst_x_ff, dst_x_in;
   logic [YW-1:0]     src_y_ff, src_y_in, dst_y_ff, dst_y_in;
   logic [VAW-1:0]    clr_addr_ff, clr_addr_in;
   logic [QIW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [XW-1:0]     cur_x_ff, cur_x_in;
   logic [YW-1:0]     cur_y_ff, cur_y_in;
   logic [DW-1:0]     cur_dist_ff, cur_dist_in;
   logic [STEP_W-1:0] k_ff, k_in;
   logic              cand_ok_ff, cand_ok_in;
   logic [XW-1:0]     cand_x_ff, cand_x_in;
   logic [YW-1:0]     cand_y_ff, cand_y_in;
   logic              found_ff, found_in;
   logic [DW-1:0]     dist_ff, dist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MOVE_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_reach_ff, rsp_reach_in;

   // memory ports
   logic           vis_we, vis_wdata, vis_re, vis_rdata;
   logic [VAW-1:0] vis_waddr, vis_raddr;
   logic           q_we, q_re;
   logic [QAW-1:0] q_waddr, q_raddr;
   logic [QW-1:0]  q_wdata, q_rdata;

   logic [COL_CMP_W-1:0] eff_cols;
   logic [ROW_CMP_W-1:0] eff_rows;
   logic                 req_fire, rsp_fire, on_board, hit, issue, add_sq, rsp_free;
   logic [XW-1:0]        q_x;
   logic [YW-1:0]        q_y;
   logic [DW-1:0]        q_dist;
   logic signed [XW+1:0] nx_s;
   logic signed [YW+1:0] ny_s;
   logic                 nb_ok;

   kmgd_sync_ram #(.WIDTH(1), .DEPTH(VDEPTH)) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .re    (vis_re),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   kmgd_sync_ram #(.WIDTH(QW), .DEPTH(NUM_SQ)) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .re    (q_re),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   // board extent, saturated to the store size
   assign eff_cols = (COL_CMP_W'(cols_ff) > COL_CMP_W'(MAX_COLS)) ?
                     COL_CMP_W'(MAX_COLS) : COL_CMP_W'(cols_ff);
   assign eff_rows = (ROW_CMP_W'(rows_ff) > ROW_CMP_W'(MAX_ROWS)) ?
                     ROW_CMP_W'(MAX_ROWS) : ROW_CMP_W'(rows_ff);

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_valid_ff && rsp_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign on_board = (COL_CMP_W'(req_if.src_x) < eff_cols)
                  && (ROW_CMP_W'(req_if.src_y) < eff_rows)
                  && (COL_CMP_W'(req_if.dst_x) < eff_cols)
                  && (ROW_CMP_W'(req_if.dst_y) < eff_rows);

   // dequeued entry
   assign q_x    = q_rdata[XW-1:0];
   assign q_y    = q_rdata[XW+YW-1:XW];
   assign q_dist = q_rdata[QW-1:XW+YW];
   assign hit    = (q_x == dst_x_ff) && (q_y == dst_y_ff);

   // neighbor of the current square for step k
   assign nx_s  = $signed({2'b00, cur_x_ff}) + (XW+2)'(step_dx(k_ff[2:0]));
   assign ny_s  = $signed({2'b00, cur_y_ff}) + (YW+2)'(step_dy(k_ff[2:0]));
   assign nb_ok = !nx_s[XW+1] && (COL_CMP_W'(nx_s[XW:0]) < eff_cols)
               && !ny_s[YW+1] && (ROW_CMP_W'(ny_s[YW:0]) < eff_rows);
   assign issue = (state_ff == ST_EXPAND) && (k_ff < STEP_W'(NUM_STEPS));

   // second stage of a lookup: square is new and the queue has room
   assign add_sq = (state_ff == ST_EXPAND) && cand_ok_ff && !vis_rdata
                && (tail_ff < QIW'(NUM_SQ));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = on_board ? ST_CLEAR : ST_DONE;
            end
         end
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: state_in = ST_POP;
         ST_POP: begin
            state_in = (head_ff == tail_ff) ? ST_DONE : ST_LOAD;
         end
         ST_LOAD: state_in = hit ? ST_DONE : ST_EXPAND;
         ST_EXPAND: begin
            if (k_ff == STEP_W'(NUM_STEPS)) begin
               state_in = ST_POP;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory controls
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      csr_if.ready = 1'b1;
      vis_we       = 1'b0;
      vis_waddr    = clr_addr_ff;
      vis_wdata    = 1'b0;
      vis_re       = issue && nb_ok;
      vis_raddr    = {ny_s[YW-1:0], nx_s[XW-1:0]};
      q_we         = 1'b0;
      q_waddr      = tail_ff[QAW-1:0];
      q_wdata      = {DW'(cur_dist_ff + DW'(1)), cand_y_ff, cand_x_ff};
      q_re         = (state_ff == ST_POP) && (head_ff != tail_ff);
      q_raddr      = head_ff[QAW-1:0];
      unique case (state_ff)
         ST_CLEAR: vis_we = 1'b1;
         ST_SEED: begin
            vis_we    = 1'b1;
            vis_waddr = {src_y_ff, src_x_ff};
            vis_wdata = 1'b1;
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = {DW'(0), src_y_ff, src_x_ff};
         end
         ST_EXPAND: begin
            vis_we    = add_sq;
            vis_waddr = {cand_y_ff, cand_x_ff};
            vis_wdata = 1'b1;
            q_we      = add_sq;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      src_x_in     = src_x_ff;
      src_y_in     = src_y_ff;
      dst_x_in     = dst_x_ff;
      dst_y_in     = dst_y_ff;
      clr_addr_in  = clr_addr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_dist_in  = cur_dist_ff;
      k_in         = k_ff;
      cand_ok_in   = issue && nb_ok;
      cand_x_in    = nx_s[XW-1:0];
      cand_y_in    = ny_s[YW-1:0];
      found_in     = found_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      rsp_count_in = rsp_count_ff;
      rsp_reach_in = rsp_reach_ff;

      // register writes
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_BOARD_COLS: cols_in = csr_if.data[COLS_W-1:0];
            CSR_BOARD_ROWS: rows_in = csr_if.data[ROWS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               src_x_in    = XW'(req_if.src_x);
               src_y_in    = YW'(req_if.src_y);
               dst_x_in    = XW'(req_if.dst_x);
               dst_y_in    = YW'(req_if.dst_y);
               clr_addr_in = '0;
               found_in    = 1'b0;
               dist_in     = '0;
            end
         end
         ST_CLEAR: clr_addr_in = clr_addr_ff + VAW'(1);
         ST_SEED: begin
            head_in = '0;
            tail_in = QIW'(1);
         end
         ST_POP: begin
            if (head_ff != tail_ff) begin
               head_in = head_ff + QIW'(1);
            end
         end
         ST_LOAD: begin
            cur_x_in    = q_x;
            cur_y_in    = q_y;
            cur_dist_in = q_dist;
            k_in        = '0;
            if (hit) begin
               found_in = 1'b1;
               dist_in  = q_dist;
            end
         end
         ST_EXPAND: begin
            k_in = k_ff + STEP_W'(1);
            if (add_sq) begin
               tail_in = tail_ff + QIW'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = found_ff ? MOVE_W'(dist_ff) : '0;
               rsp_reach_in = found_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         k_ff         <= '0;
         cand_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         k_ff         <= k_in;
         cand_ok_ff   <= cand_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_x_ff     <= src_x_in;
      src_y_ff     <= src_y_in;
      dst_x_ff     <= dst_x_in;
      dst_y_ff     <= dst_y_in;
      clr_addr_ff  <= clr_addr_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      cur_dist_ff  <= cur_dist_in;
      cand_x_ff    <= cand_x_in;
      cand_y_ff    <= cand_y_in;
      found_ff     <= found_in;
      dist_ff      <= dist_in;
      rsp_count_ff <= rsp_count_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.move_count = rsp_count_ff;
   assign rsp_if.reachable  = rsp_reach_ff;

`ifndef SYNTHESIS
   // queue read pointer never passes the write pointer
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   // every queued square is marked visited in the same cycle
   a_queue_marks: assert property (@(posedge clock) disable iff (reset)
      q_we |-> (vis_we && vis_wdata))
      else $error("queue write without visited mark");

   // an accepted query starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("query accepted but block stayed idle");

   // reaching the target ends the walk with a found result
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && hit) |=> (state_ff == ST_DONE && found_ff))
      else $error("target dequeued but walk did not finish");
`endif

endmodule

>>> verif/knight_move_grid_distance_tb.sv
module knight_move_grid_distance_tb
   import kmgd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BOARD_SQUARES = DEF_MAX_COLS * DEF_MAX_ROWS;
   localparam int CYCLE_LIMIT   = 16_000_000;
   localparam int LONG_STALL    = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 10;
   localparam int HOP_DX [NUM_STEPS] = '{1, 1, -1, -1, 2, 2, -2, -2};
   localparam int HOP_DY [NUM_STEPS] = '{2, -2, 2, -2, 1, -1, 1, -1};

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct packed {
      logic [MOVE_W-1:0] move_count;
      logic              reachable;
   } hop_answer_type;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_ASK,
      ROW_ASK_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [X_FIELD_W-1:0]  sx;
      logic [Y_FIELD_W-1:0]  sy;
      logic [X_FIELD_W-1:0]  tx;
      logic [Y_FIELD_W-1:0]  ty;
      hop_answer_type        typed_ans;
   } stim_row_type;

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_CFG;
      r.index = idx;
      r.data  = value;
      return r;
   endfunction

   function automatic stim_row_type ask_row(input int sx, input int sy, input int tx,
                                            input int ty);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ASK;
      r.sx   = sx[X_FIELD_W-1:0];
      r.sy   = sy[Y_FIELD_W-1:0];
      r.tx   = tx[X_FIELD_W-1:0];
      r.ty   = ty[Y_FIELD_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type typed_row(input int sx, input int sy, input int tx,
                                              input int ty, input int hops,
                                              input bit reach);
      stim_row_type r;
      r = ask_row(sx, sy, tx, ty);
      r.kind = ROW_ASK_TYPED;
      r.typed_ans.move_count = hops[MOVE_W-1:0];
      r.typed_ans.reachable  = reach;
      return r;
   endfunction

   localparam int DIRECTED_ROWS = 32;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // reset board 8x8
      typed_row(0, 0, 0, 0, 0, 1'b1),
      ask_row(0, 0, 7, 7),
      typed_row(0, 0, 1, 2, 1, 1'b1),
      typed_row(8, 0, 0, 0, 0, 1'b0),
      typed_row(0, 0, 0, 63, 0, 1'b0),
      typed_row(31, 63, 31, 63, 0, 1'b0),
      // largest board
      cfg_row(CSR_BOARD_COLS, 7'd32),
      cfg_row(CSR_BOARD_ROWS, 7'd64),
      ask_row(0, 0, 31, 63),
      typed_row(31, 63, 31, 63, 0, 1'b1),
      // extents above the store saturate
      cfg_row(CSR_BOARD_COLS, 7'h7F),
      cfg_row(CSR_BOARD_ROWS, 7'h7F),
      ask_row(31, 0, 0, 63),
      ask_row(0, 0, 1, 1),
      // single square
      cfg_row(CSR_BOARD_COLS, 7'd1),
      cfg_row(CSR_BOARD_ROWS, 7'd1),
      typed_row(0, 0, 0, 0, 0, 1'b1),
      typed_row(0, 0, 1, 0, 0, 1'b0),
      // 3x3: center cannot be reached
      cfg_row(CSR_BOARD_COLS, 7'd3),
      cfg_row(CSR_BOARD_ROWS, 7'd3),
      ask_row(0, 0, 1, 1),
      ask_row(0, 0, 2, 1),
      // writes to unused indexes leave the board alone
      cfg_row(CSR_UNUSED_A, 7'h01),
      cfg_row(CSR_UNUSED_B, 7'h7F),
      ask_row(2, 2, 0, 0),
      // top data bit is dropped for columns: zero columns
      cfg_row(CSR_BOARD_COLS, 7'h40),
      typed_row(0, 0, 0, 0, 0, 1'b0),
      // zero rows
      cfg_row(CSR_BOARD_COLS, 7'h48),
      cfg_row(CSR_BOARD_ROWS, 7'd0),
      typed_row(0, 0, 0, 0, 0, 1'b0),
      // tall narrow board
      cfg_row(CSR_BOARD_ROWS, 7'h3F),
      ask_row(0, 0, 7, 62)
   };

   logic clock;
   logic reset;

   kmgd_req_if req_ch ();
   kmgd_rsp_if rsp_ch ();
   kmgd_csr_if csr_ch ();

   knight_move_grid_distance dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // shadow of the board registers
   logic [COLS_W-1:0] board_cols_shadow = COLS_RESET;
   logic [ROWS_W-1:0] board_rows_shadow = ROWS_RESET;

   hop_answer_type expected_answers [$];
   int          fail_count   = 0;
   int          cycle_count  = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_token  = 0;
   int          stall_seen   = 0;
   int          stall_left   = 0;

   // search scratch
   bit square_seen [BOARD_SQUARES];
   int walk_square [BOARD_SQUARES];
   int walk_hops   [BOARD_SQUARES];

   function automatic int eff_cols();
      return (board_cols_shadow > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(board_cols_shadow);
   endfunction

   function automatic int eff_rows();
      return (board_rows_shadow > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(board_rows_shadow);
   endfunction

   // fewest knight hops by breadth-first walk over the current board
   function automatic hop_answer_type knight_hops(input logic [X_FIELD_W-1:0] sx,
                                                  input logic [Y_FIELD_W-1:0] sy,
                                                  input logic [X_FIELD_W-1:0] tx,
                                                  input logic [Y_FIELD_W-1:0] ty);
      hop_answer_type ans;
      int cols, rows, head, tail, cur, cx, cy, nx, ny, sq, target;
      ans  = '0;
      cols = eff_cols();
      rows = eff_rows();
      if (int'(sx) < cols && int'(sy) < rows && int'(tx) < cols && int'(ty) < rows) begin
         foreach (square_seen[i]) square_seen[i] = 1'b0;
         target = int'(ty) * DEF_MAX_COLS + int'(tx);
         walk_square[0] = int'(sy) * DEF_MAX_COLS + int'(sx);
         walk_hops[0]   = 0;
         square_seen[walk_square[0]] = 1'b1;
         head = 0;
         tail = 1;
         while (head < tail && !ans.reachable) begin
            cur = walk_square[head];
            if (cur == target) begin
               ans.move_count = walk_hops[head][MOVE_W-1:0];
               ans.reachable  = 1'b1;
            end else begin
               cx = cur % DEF_MAX_COLS;
               cy = cur / DEF_MAX_COLS;
               for (int k = 0; k < NUM_STEPS; k++) begin
                  nx = cx + HOP_DX[k];
                  ny = cy + HOP_DY[k];
                  if (nx >= 0 && nx < cols && ny >= 0 && ny < rows) begin
                     sq = ny * DEF_MAX_COLS + nx;
                     if (!square_seen[sq]) begin
                        square_seen[sq]   = 1'b1;
                        walk_square[tail] = sq;
                        walk_hops[tail]   = walk_hops[head] + 1;
                        tail++;
                     end
                  end
               end
            end
            head++;
         end
      end
      return ans;
   endfunction

   // sender pause: hold the query channel until every answer is back
   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   // board register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_for_answers();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_BOARD_COLS: board_cols_shadow = value[COLS_W-1:0];
         CSR_BOARD_ROWS: board_rows_shadow = value[ROWS_W-1:0];
         default: ;
      endcase
   endtask

   // offer one query; valid stays high on return so items can go back to back
   task automatic send_query(input logic [X_FIELD_W-1:0] sx, input logic [Y_FIELD_W-1:0] sy,
                             input logic [X_FIELD_W-1:0] tx, input logic [Y_FIELD_W-1:0] ty,
                             input bit typed, input hop_answer_type typed_ans);
      csr_ch.valid <= 1'b0;
      if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.src_x <= sx;
      req_ch.src_y <= sy;
      req_ch.dst_x <= tx;
      req_ch.dst_y <= ty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_answers.push_back(typed ? typed_ans : knight_hops(sx, sy, tx, ty));
   endtask

   // mostly on-board queries, some near or equal squares, some raw field noise
   task automatic random_query();
      int ec, er, pick, nx, ny;
      logic [X_FIELD_W-1:0] sx, tx;
      logic [Y_FIELD_W-1:0] sy, ty;
      ec   = eff_cols();
      er   = eff_rows();
      pick = $urandom_range(99, 0);
      if (pick < 15 || ec == 0 || er == 0) begin
         sx = X_FIELD_W'($urandom_range(31, 0));
         sy = Y_FIELD_W'($urandom_range(63, 0));
         tx = X_FIELD_W'($urandom_range(31, 0));
         ty = Y_FIELD_W'($urandom_range(63, 0));
      end else begin
         sx = X_FIELD_W'($urandom_range(ec - 1, 0));
         sy = Y_FIELD_W'($urandom_range(er - 1, 0));
         if (pick < 25) begin
            tx = sx;
            ty = sy;
         end else if (pick < 50) begin
            nx = int'(sx) + int'($urandom_range(4, 0)) - 2;
            ny = int'(sy) + int'($urandom_range(4, 0)) - 2;
            nx = (nx < 0) ? 0 : (nx >= ec) ? ec - 1 : nx;
            ny = (ny < 0) ? 0 : (ny >= er) ? er - 1 : ny;
            tx = nx[X_FIELD_W-1:0];
            ty = ny[Y_FIELD_W-1:0];
         end else begin
            tx = X_FIELD_W'($urandom_range(ec - 1, 0));
            ty = Y_FIELD_W'($urandom_range(er - 1, 0));
         end
      end
      send_query(sx, sy, tx, ty, 1'b0, '0);
   endtask

   // answer checker and receiver ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected answer: move_count %0d reachable %0b",
                           rsp_ch.move_count, rsp_ch.reachable);
            end else begin
               if (rsp_ch.move_count !== expected_answers[0].move_count ||
                   rsp_ch.reachable !== expected_answers[0].reachable) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("answer mismatch: expected %0d %0b, got %0d %0b",
                              expected_answers[0].move_count, expected_answers[0].reachable,
                              rsp_ch.move_count, rsp_ch.reachable);
               end
               void'(expected_answers.pop_front());
            end
         end
         if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("knight_move_grid_distance_tb: errors");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.src_x = '0;
      req_ch.src_y = '0;
      req_ch.dst_x = '0;
      req_ch.dst_y = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      send_idle_pct = 11;
      recv_idle_pct = 52;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         case (DIRECTED[i].kind)
            ROW_CFG:
               write_reg(DIRECTED[i].index, DIRECTED[i].data);
            ROW_ASK:
               send_query(DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].tx, DIRECTED[i].ty,
                          1'b0, '0);
            default:
               send_query(DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].tx, DIRECTED[i].ty,
                          1'b1, DIRECTED[i].typed_ans);
         endcase
      end

      // random part: three idling mixes, four boards each
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 52 : 0;
         recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 11 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            if (blk == 0)
               write_reg(CSR_UNUSED_A, 7'($urandom_range(127, 0)));
            if (blk == 2) begin
               write_reg(CSR_BOARD_COLS, 7'($urandom_range(24, 12)));
               write_reg(CSR_BOARD_ROWS, 7'($urandom_range(20, 8)));
            end else if (blk == 3) begin
               write_reg(CSR_BOARD_COLS, 7'($urandom_range(6, 1)));
               write_reg(CSR_BOARD_ROWS, 7'($urandom_range(127, 0)));
            end else begin
               write_reg(CSR_BOARD_COLS, 7'($urandom_range(10, 1)));
               write_reg(CSR_BOARD_ROWS, 7'($urandom_range(12, 1)));
            end
            for (int n = 0; n < 8; n++) random_query();

            // long receiver hold while quick off-board queries pile up
            if (phase == 2 && blk == 1) begin
               stall_token++;
               for (int n = 0; n < 6; n++)
                  send_query(5'd31, 6'd63, 5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)),
                             1'b0, '0);
               wait_for_answers();
            end
         end
      end

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_answers.size() == 0) begin
         $display("knight_move_grid_distance_tb: clean");
      end else begin
         $display("knight_move_grid_distance_tb: errors");
      end
      $finish;
   end

endmodule
